@@ rtl/sirs_pkg.sv @@
// shared types, constants and helpers of the signed integer to radix text block
package sirs_pkg;

    localparam int VALUE_W      = 64;
    localparam int RADIX_W      = 6;
    localparam int LEN_W        = 7;
    localparam int CHAR_W       = 7;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 7;

    localparam int STORE_DEPTH  = 64;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    localparam int OUT_CHARS_DEF = 64;

    // divider retires this many quotient bits per clock
    localparam int DIV_BITS     = 8;
    localparam int DIV_CYCLES   = VALUE_W / DIV_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_RST   = 6'd10;
    localparam logic [LEN_W-1:0]   LEN_RST     = 7'd50;

    localparam logic [CHAR_W-1:0]  CH_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0]  CH_ALPHA    = 7'h41;
    localparam logic [CHAR_W-1:0]  CH_MINUS    = 7'h2D;
    localparam logic [CHAR_W-1:0]  CH_NUL      = 7'h00;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN   = 8'd1;

    typedef struct packed {
        logic                 start;
        logic [VALUE_W-1:0]   dividend;
        logic [RADIX_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [RADIX_W-1:0]   remainder;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_DIGITS) begin
            ch = CH_ZERO + {1'b0, d};
        end else begin
            ch = CH_ALPHA + {1'b0, d} - {1'b0, DEC_DIGITS};
        end
        return ch;
    endfunction

endpackage

@@ rtl/sirs_div.sv @@
// iterative 64-bit by 6-bit restoring divider, several quotient bits per clock
module sirs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sirs_pkg::t_div_req i_req,
    output sirs_pkg::t_div_rsp o_rsp
);
    import sirs_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [VALUE_W-1:0]    r_work;
    logic [RADIX_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    r_div;

    logic [VALUE_W-1:0]    n_work;
    logic [RADIX_W-1:0]    n_rem;
    logic [RADIX_W:0]      w_trial;

    // remainder stays below the divisor, so each trial value fits radix width + 1
    always_comb begin
        n_work  = r_work;
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            w_trial = {n_rem, n_work[VALUE_W-1]};
            n_work  = {n_work[VALUE_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                w_trial   = w_trial - {1'b0, r_div};
                n_work[0] = 1'b1;
            end
            n_rem = w_trial[RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_work;
    assign o_rsp.remainder = r_rem;

endmodule

@@ rtl/sirs_store.sv @@
// digit memory, one write and one registered read port
module sirs_store (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [sirs_pkg::STORE_AW-1:0]  i_waddr,
    input  logic [sirs_pkg::RADIX_W-1:0]   i_wdata,
    input  logic [sirs_pkg::STORE_AW-1:0]  i_raddr,
    output logic [sirs_pkg::RADIX_W-1:0]   o_rdata
);
    import sirs_pkg::*;

    logic [RADIX_W-1:0] r_mem [STORE_DEPTH];
    logic [RADIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/signed_int_to_radix_string.sv @@
// top level: signed 64-bit value to ascii text in a configurable base
//
// A request is taken when i_start is high and o_busy is low. The magnitude is
// broken into digits, least significant first, by one shared divider that
// retires 8 quotient bits per clock, so each digit takes a load plus 8 steps;
// a value has at most 64 digits, in base 2. The characters then leave one per
// clock from the digit memory, sign first and most significant digit first.
// Results come out on o_strobe for one cycle each and cannot be held off;
// o_last marks the final character and o_char_count carries the character
// count there. Text longer than the buffer length is cut to length-1
// characters plus a zero byte; a buffer length of one gives only the zero
// byte. A radix outside 2..36 or a zero buffer length gives no results and
// o_busy never rises. Configuration writes are taken at any time but are
// meant to land only while o_busy is low.
module signed_int_to_radix_string #(
    parameter int OUT_CHARS = sirs_pkg::OUT_CHARS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request side
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [sirs_pkg::VALUE_W-1:0] i_value,
    // result side
    output logic                             o_strobe,
    output logic [sirs_pkg::CHAR_W-1:0]      o_character,
    output logic                             o_last,
    output logic [sirs_pkg::LEN_W-1:0]       o_char_count,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sirs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sirs_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // character kinds in the output stage
    localparam logic [1:0] KIND_NUL   = 2'd0;
    localparam logic [1:0] KIND_MINUS = 2'd1;
    localparam logic [1:0] KIND_DIGIT = 2'd2;

    // configuration registers
    logic [RADIX_W-1:0] r_radix;
    logic [LEN_W-1:0]   r_len;

    // sequencer
    logic [1:0]         r_state;
    logic               r_neg;
    logic [LEN_W-1:0]   r_ndig;     // digits stored so far
    logic [LEN_W-1:0]   r_idx;      // character being fetched
    logic [LEN_W-1:0]   r_count;    // characters in this request
    logic               r_trunc;

    // output stage
    logic               r_o_valid;
    logic [1:0]         r_o_kind;
    logic               r_o_last;

    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    logic [RADIX_W-1:0] w_rdata;

    logic               w_accept;
    logic               w_cfg_ok;
    logic [LEN_W-1:0]   w_cap;
    logic [VALUE_W-1:0] w_mag;
    logic [LEN_W-1:0]   w_ndig_inc;
    logic               w_more;
    logic [LEN_W-1:0]   w_total;
    logic [LEN_W-1:0]   w_pos;
    logic               w_is_nul;
    logic               w_is_minus;
    logic               w_is_last;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != S_IDLE) || r_o_valid;
    assign w_accept    = i_start && !o_busy;

    // buffer length above the build limit acts as the limit
    assign w_cap    = (r_len > LEN_W'(OUT_CHARS)) ? LEN_W'(OUT_CHARS) : r_len;
    assign w_cfg_ok = (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX) && (r_len != '0);

    // most negative value wraps to 2^63, which is right as an unsigned magnitude
    assign w_mag = i_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'($unsigned(i_value)))
                                      : VALUE_W'($unsigned(i_value));

    // digit loop bookkeeping
    assign w_ndig_inc = r_ndig + 1'b1;
    assign w_more     = (w_div_rsp.quotient != '0) && (w_ndig_inc < LEN_W'(STORE_DEPTH));
    assign w_total    = w_ndig_inc + {{(LEN_W-1){1'b0}}, r_neg};

    // emit side: sign, digits from most significant, or the truncation zero
    assign w_is_nul   = r_trunc && (r_idx == w_cap - 1'b1);
    assign w_is_minus = r_neg && (r_idx == '0);
    assign w_is_last  = (r_idx == r_count - 1'b1);
    assign w_pos      = r_ndig - 1'b1 + {{(LEN_W-1){1'b0}}, r_neg} - r_idx;

    // divider feed: first digit from the magnitude, later ones from the quotient
    assign w_div_req.start    = (w_accept && w_cfg_ok && (w_cap != LEN_W'(1))) ||
                                ((r_state == S_DIV) && w_div_rsp.done && w_more);
    assign w_div_req.dividend = (r_state == S_IDLE) ? w_mag : w_div_rsp.quotient;
    assign w_div_req.divisor  = r_radix;

    sirs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    sirs_store u_store (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_DIV) && w_div_rsp.done),
        .i_waddr (r_ndig[STORE_AW-1:0]),
        .i_wdata (w_div_rsp.remainder),
        .i_raddr (w_pos[STORE_AW-1:0]),
        .o_rdata (w_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
            r_len   <= LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_RADIX: begin
                    r_radix <= i_cfg_data[RADIX_W-1:0];
                end
                REG_LEN: begin
                    r_len <= i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_neg     <= 1'b0;
            r_ndig    <= '0;
            r_idx     <= '0;
            r_count   <= '0;
            r_trunc   <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_kind  <= KIND_NUL;
            r_o_last  <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_cfg_ok) begin
                        if (w_cap == LEN_W'(1)) begin
                            // buffer of one: only the zero byte
                            r_o_valid <= 1'b1;
                            r_o_kind  <= KIND_NUL;
                            r_o_last  <= 1'b1;
                            r_count   <= LEN_W'(1);
                        end else begin
                            r_neg   <= i_value[VALUE_W-1];
                            r_ndig  <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_ndig <= w_ndig_inc;
                        if (!w_more) begin
                            r_idx   <= '0;
                            r_count <= (w_total <= w_cap) ? w_total : w_cap;
                            r_trunc <= (w_total > w_cap);
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    r_o_valid <= 1'b1;
                    r_o_last  <= w_is_last;
                    if (w_is_nul) begin
                        r_o_kind <= KIND_NUL;
                    end else if (w_is_minus) begin
                        r_o_kind <= KIND_MINUS;
                    end else begin
                        r_o_kind <= KIND_DIGIT;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (w_is_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // character formed from the registered kind and the memory read
    always_comb begin
        case (r_o_kind)
            KIND_NUL:   o_character = CH_NUL;
            KIND_MINUS: o_character = CH_MINUS;
            default:    o_character = digit_char(w_rdata);
        endcase
    end

    assign o_strobe     = r_o_valid;
    assign o_last       = r_o_valid && r_o_last;
    assign o_char_count = (r_o_valid && r_o_last) ? r_count : '0;

endmodule

@@ rtl/sirs_chk.sv @@
// port-level checker for the radix text block, bound to the top level
module sirs_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_busy,
    input logic                         o_strobe,
    input logic [sirs_pkg::CHAR_W-1:0]  o_character,
    input logic                         o_last,
    input logic [sirs_pkg::LEN_W-1:0]   o_char_count
);
    import sirs_pkg::*;

    // count only shows on the final character, and is never zero there
    a_count_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last ? (o_char_count != '0) : (o_char_count == '0)))
        else $error("char count outside the final character");

    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last without strobe");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_character == CH_NUL) || (o_character == CH_MINUS) ||
                      ((o_character >= CH_ZERO) && (o_character <= 7'h39)) ||
                      ((o_character >= CH_ALPHA) && (o_character <= 7'h5A))))
        else $error("illegal character");

    // a request only finishes on its final character
    a_busy_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(o_strobe && o_last))
        else $error("busy dropped without a final character");

    // the final character is not directly followed by another strobe
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("character after the final one");

endmodule

bind signed_int_to_radix_string sirs_chk u_sirs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_busy       (o_busy),
    .o_strobe     (o_strobe),
    .o_character  (o_character),
    .o_last       (o_last),
    .o_char_count (o_char_count)
);
